// ===== rtl/sample_history_ring_with_cursor_query_top_assert.svh =====
// Assertion macros for the sample history ring checker.
`ifndef SAMPLE_HISTORY_RING_WITH_CURSOR_QUERY_TOP_ASSERT_SVH
`define SAMPLE_HISTORY_RING_WITH_CURSOR_QUERY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SHRQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shrq check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SHRQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shrq check failed");

`endif

// ===== rtl/shrq_pkg.sv =====
// Shared types and codes for the sample history ring: record, result beat, kinds and states.
`timescale 1ns / 1ps

package shrq_pkg;

   localparam logic KIND_PUSH  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [63:0] id;
      logic [63:0] time_us;
      logic [63:0] volts_bits;
      logic [63:0] amps_bits;
      logic [31:0] quality;
      logic [31:0] revision;
   } rec_type;

   typedef struct packed {
      logic        has_sample;
      rec_type     rec;
      logic [63:0] oldest_id;
      logic [63:0] newest_id;
      logic        lost;
      logic [63:0] cursor;
      logic        last;
   } rsp_type;

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_OLD_RD  = 13'b0000000000010,
      ST_OLD_TK  = 13'b0000000000100,
      ST_NEW_RD  = 13'b0000000001000,
      ST_NEW_TK  = 13'b0000000010000,
      ST_SRCH    = 13'b0000000100000,
      ST_SRCH_TK = 13'b0000001000000,
      ST_CNT     = 13'b0000010000000,
      ST_CUR_RD  = 13'b0000100000000,
      ST_CUR_TK  = 13'b0001000000000,
      ST_REC_RD  = 13'b0010000000000,
      ST_REC_TK  = 13'b0100000000000,
      ST_OUT     = 13'b1000000000000
   } state_type;

endpackage

// ===== rtl/shrq_ring.sv =====
// Record memory of the history ring: one write port, one registered read port.
`timescale 1ns / 1ps

module shrq_ring #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  shrq_pkg::rec_type wr_data,
   input  logic [AW-1:0]     rd_addr,
   output shrq_pkg::rec_type rd_data
);

   shrq_pkg::rec_type mem [DEPTH];
   shrq_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/shrq_seq.sv =====
// Query sequencer: ends read, binary search and batch readout over one slot unit.
`timescale 1ns / 1ps

module shrq_seq #(
   parameter int RING_DEPTH = 2048,
   parameter int BATCH_MAX  = 48,
   parameter int PW         = 11,
   parameter int CW         = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [63:0]       start_after,
   input  logic [CW-1:0]     used,
   input  logic [PW-1:0]     base,
   output logic [PW-1:0]     rd_addr,
   input  shrq_pkg::rec_type rd_data,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output shrq_pkg::rsp_type rsp
);

   localparam int BW = $clog2(BATCH_MAX + 1);
   localparam int KW = (CW > BW) ? CW : BW;

   shrq_pkg::state_type state_ff, state_in;
   logic [63:0]       after_ff, after_in;
   logic [CW-1:0]     used_ff, used_in;
   logic [PW-1:0]     base_ff, base_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [BW-1:0]     cnt_ff, cnt_in;
   logic [BW-1:0]     idx_ff, idx_in;
   logic [63:0]       oldest_ff, oldest_in;
   logic [63:0]       newest_ff, newest_in;
   logic              lost_ff, lost_in;
   logic [63:0]       cursor_ff, cursor_in;
   shrq_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0]     mid;
   logic [CW-1:0]     diff;
   logic [CW-1:0]     slot_pos;
   logic [CW:0]       slot_sum;
   logic [CW:0]       slot_wrap;

   assign mid  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign diff = used_ff - lo_ff;

   always_comb begin
      unique case (state_ff)
         shrq_pkg::ST_NEW_RD: slot_pos = used_ff - CW'(1);
         shrq_pkg::ST_SRCH:   slot_pos = mid;
         shrq_pkg::ST_CUR_RD: slot_pos = CW'(KW'(lo_ff) + KW'(cnt_ff) - KW'(1));
         shrq_pkg::ST_REC_RD: slot_pos = CW'(KW'(lo_ff) + KW'(idx_ff));
         default:             slot_pos = '0;
      endcase
   end

   assign slot_sum  = (CW+1)'(base_ff) + (CW+1)'(slot_pos);
   assign slot_wrap = (slot_sum >= (CW+1)'(RING_DEPTH)) ?
                      slot_sum - (CW+1)'(RING_DEPTH) : slot_sum;
   assign rd_addr   = slot_wrap[PW-1:0];

   always_comb begin
      state_in  = state_ff;
      after_in  = after_ff;
      used_in   = used_ff;
      base_in   = base_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      oldest_in = oldest_ff;
      newest_in = newest_ff;
      lost_in   = lost_ff;
      cursor_in = cursor_ff;
      rsp_in    = rsp_ff;
      unique case (state_ff)
         shrq_pkg::ST_IDLE: begin
            if (start) begin
               after_in  = start_after;
               used_in   = used;
               base_in   = base;
               lo_in     = '0;
               hi_in     = '0;
               oldest_in = '0;
               newest_in = '0;
               lost_in   = 1'b0;
               state_in  = (used == '0) ? shrq_pkg::ST_CNT : shrq_pkg::ST_OLD_RD;
            end
         end
         shrq_pkg::ST_OLD_RD: state_in = shrq_pkg::ST_OLD_TK;
         shrq_pkg::ST_OLD_TK: begin
            oldest_in = rd_data.id;
            state_in  = shrq_pkg::ST_NEW_RD;
         end
         shrq_pkg::ST_NEW_RD: state_in = shrq_pkg::ST_NEW_TK;
         shrq_pkg::ST_NEW_TK: begin
            newest_in = rd_data.id;
            lost_in   = (after_ff != '0) && (oldest_ff != '0) &&
                        ((after_ff + 64'd1) < oldest_ff);
            if (after_ff == '0) begin
               lo_in    = (KW'(used_ff) > KW'(BATCH_MAX)) ?
                          CW'(KW'(used_ff) - KW'(BATCH_MAX)) : '0;
               state_in = shrq_pkg::ST_CNT;
            end else begin
               lo_in    = '0;
               hi_in    = used_ff;
               state_in = shrq_pkg::ST_SRCH;
            end
         end
         shrq_pkg::ST_SRCH: begin
            state_in = (lo_ff < hi_ff) ? shrq_pkg::ST_SRCH_TK : shrq_pkg::ST_CNT;
         end
         shrq_pkg::ST_SRCH_TK: begin
            if (rd_data.id <= after_ff) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = shrq_pkg::ST_SRCH;
         end
         shrq_pkg::ST_CNT: begin
            cnt_in = (KW'(diff) > KW'(BATCH_MAX)) ? BW'(BATCH_MAX) : BW'(diff);
            idx_in = '0;
            if (diff == '0) begin
               rsp_in.has_sample = 1'b0;
               rsp_in.rec        = '0;
               rsp_in.oldest_id  = oldest_ff;
               rsp_in.newest_id  = newest_ff;
               rsp_in.lost       = lost_ff;
               rsp_in.cursor     = after_ff;
               rsp_in.last       = 1'b1;
               state_in          = shrq_pkg::ST_OUT;
            end else begin
               state_in = shrq_pkg::ST_CUR_RD;
            end
         end
         shrq_pkg::ST_CUR_RD: state_in = shrq_pkg::ST_CUR_TK;
         shrq_pkg::ST_CUR_TK: begin
            cursor_in = rd_data.id;
            state_in  = shrq_pkg::ST_REC_RD;
         end
         shrq_pkg::ST_REC_RD: state_in = shrq_pkg::ST_REC_TK;
         shrq_pkg::ST_REC_TK: begin
            rsp_in.has_sample = 1'b1;
            rsp_in.rec        = rd_data;
            rsp_in.oldest_id  = oldest_ff;
            rsp_in.newest_id  = newest_ff;
            rsp_in.lost       = lost_ff;
            rsp_in.cursor     = cursor_ff;
            rsp_in.last       = (idx_ff + BW'(1)) == cnt_ff;
            state_in          = shrq_pkg::ST_OUT;
         end
         shrq_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               if (rsp_ff.last) begin
                  state_in = shrq_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + BW'(1);
                  state_in = shrq_pkg::ST_REC_RD;
               end
            end
         end
         default: state_in = shrq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shrq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      after_ff  <= after_in;
      used_ff   <= used_in;
      base_ff   <= base_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      oldest_ff <= oldest_in;
      newest_ff <= newest_in;
      lost_ff   <= lost_in;
      cursor_ff <= cursor_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = state_ff != shrq_pkg::ST_IDLE;
   assign rsp_valid = state_ff == shrq_pkg::ST_OUT;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/sample_history_ring_with_cursor_query_top.sv =====
// Top level of the sample history ring with cursor query.
`timescale 1ns / 1ps

// Keeps the last RING_DEPTH sample records. A push beat (kind 0) is taken when the block
// is idle and writes the slot at the write pointer, overwriting the oldest record once the
// ring is full; it gives no result. A query beat (kind 1) holds req_stall high until its
// last result beat is taken. All work goes through one record memory with a single
// registered read port. A query reads the oldest and newest ids, runs a binary search
// when the cursor is nonzero, sizes the batch, fetches the new cursor, then reads and
// returns each record in turn, waiting out any rsp_stall. An empty answer gives one beat
// with has_sample low; on an empty ring the id reads and the search are skipped.

module sample_history_ring_with_cursor_query_top #(
   parameter int RING_DEPTH = 2048,
   parameter int BATCH_MAX  = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [63:0] req_sample_id,
   input  logic [63:0] req_time_us,
   input  logic [63:0] req_volts_bits,
   input  logic [63:0] req_amps_bits,
   input  logic [31:0] req_quality,
   input  logic [31:0] req_revision,
   input  logic [63:0] req_after_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_has_sample,
   output logic [63:0] rsp_out_id,
   output logic [63:0] rsp_out_time_us,
   output logic [63:0] rsp_out_volts_bits,
   output logic [63:0] rsp_out_amps_bits,
   output logic [31:0] rsp_out_quality,
   output logic [31:0] rsp_out_revision,
   output logic [63:0] rsp_oldest_id,
   output logic [63:0] rsp_newest_id,
   output logic        rsp_lost,
   output logic [63:0] rsp_cursor,
   output logic        rsp_last
);

   localparam int PW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);

   logic [PW-1:0]     wp_ff, wp_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic              busy;
   logic              accept;
   logic              push;
   logic              query;
   logic [CW:0]       base_sum;
   logic [CW:0]       base_wrap;
   logic [PW-1:0]     rd_addr;
   shrq_pkg::rec_type wr_data;
   shrq_pkg::rec_type rd_data;
   shrq_pkg::rsp_type rsp;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign push      = accept && (req_kind == shrq_pkg::KIND_PUSH);
   assign query     = accept && (req_kind == shrq_pkg::KIND_QUERY);

   assign wr_data.id         = req_sample_id;
   assign wr_data.time_us    = req_time_us;
   assign wr_data.volts_bits = req_volts_bits;
   assign wr_data.amps_bits  = req_amps_bits;
   assign wr_data.quality    = req_quality;
   assign wr_data.revision   = req_revision;

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(RING_DEPTH - 1)) ? '0 : wp_ff + PW'(1);
         if (fill_ff != CW'(RING_DEPTH)) begin
            fill_in = fill_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   assign base_sum  = (CW+1)'(wp_ff) + (CW+1)'(RING_DEPTH) - (CW+1)'(fill_ff);
   assign base_wrap = (base_sum >= (CW+1)'(RING_DEPTH)) ?
                      base_sum - (CW+1)'(RING_DEPTH) : base_sum;

   shrq_ring #(
      .DEPTH (RING_DEPTH),
      .AW    (PW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   shrq_seq #(
      .RING_DEPTH (RING_DEPTH),
      .BATCH_MAX  (BATCH_MAX),
      .PW         (PW),
      .CW         (CW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (query),
      .start_after (req_after_id),
      .used        (fill_ff),
      .base        (base_wrap[PW-1:0]),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   assign rsp_has_sample     = rsp.has_sample;
   assign rsp_out_id         = rsp.rec.id;
   assign rsp_out_time_us    = rsp.rec.time_us;
   assign rsp_out_volts_bits = rsp.rec.volts_bits;
   assign rsp_out_amps_bits  = rsp.rec.amps_bits;
   assign rsp_out_quality    = rsp.rec.quality;
   assign rsp_out_revision   = rsp.rec.revision;
   assign rsp_oldest_id      = rsp.oldest_id;
   assign rsp_newest_id      = rsp.newest_id;
   assign rsp_lost           = rsp.lost;
   assign rsp_cursor         = rsp.cursor;
   assign rsp_last           = rsp.last;

endmodule

// ===== rtl/shrq_checker.sv =====
// Port checker for the sample history ring, bound to the top level.
`timescale 1ns / 1ps
`include "sample_history_ring_with_cursor_query_top_assert.svh"

module shrq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_has_sample,
   input logic [63:0] rsp_out_id,
   input logic [63:0] rsp_cursor,
   input logic        rsp_last
);

   `SHRQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SHRQ_ASSERT_NOW(a_busy_on_rsp, clock, reset, rsp_valid, req_stall)
   `SHRQ_ASSERT_NOW(a_empty_is_last, clock, reset, rsp_valid && !rsp_has_sample, rsp_last)
   `SHRQ_ASSERT_NOW(a_last_cursor, clock, reset, rsp_valid && rsp_has_sample && rsp_last,
                    rsp_cursor == rsp_out_id)

endmodule

bind sample_history_ring_with_cursor_query_top shrq_checker u_shrq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_has_sample (rsp_has_sample),
   .rsp_out_id     (rsp_out_id),
   .rsp_cursor     (rsp_cursor),
   .rsp_last       (rsp_last)
);

// ===== tb/tb_sample_history_ring_with_cursor_query_top.sv =====
// Testbench for the sample history ring: predicts every query answer and checks each result beat.
`timescale 1ns / 1ps

module tb_sample_history_ring_with_cursor_query_top;

   localparam int          DEPTH       = 2048;
   localparam int          BATCH       = 48;
   localparam int unsigned QUIET_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = shrq_pkg::KIND_PUSH;
   logic [63:0] req_sample_id = '0;
   logic [63:0] req_time_us = '0;
   logic [63:0] req_volts_bits = '0;
   logic [63:0] req_amps_bits = '0;
   logic [31:0] req_quality = '0;
   logic [31:0] req_revision = '0;
   logic [63:0] req_after_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_has_sample;
   logic [63:0] rsp_out_id;
   logic [63:0] rsp_out_time_us;
   logic [63:0] rsp_out_volts_bits;
   logic [63:0] rsp_out_amps_bits;
   logic [31:0] rsp_out_quality;
   logic [31:0] rsp_out_revision;
   logic [63:0] rsp_oldest_id;
   logic [63:0] rsp_newest_id;
   logic        rsp_lost;
   logic [63:0] rsp_cursor;
   logic        rsp_last;

   shrq_pkg::rec_type history [DEPTH];
   int unsigned       hist_wr = 0;
   int unsigned       hist_fill = 0;
   shrq_pkg::rsp_type pending_answers [$];
   logic [63:0]       viewer_cursor = '0;
   logic [63:0]       next_sample_id = 64'd2000;
   int unsigned       mismatches = 0;
   int unsigned       quiet_cycles = 0;
   int unsigned       hold_request = 0;
   int unsigned       stall_left = 0;
   bit                sender_idles = 1'b1;
   bit                receiver_idles = 1'b1;

   sample_history_ring_with_cursor_query_top #(
      .RING_DEPTH(DEPTH),
      .BATCH_MAX (BATCH)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_sample_id     (req_sample_id),
      .req_time_us       (req_time_us),
      .req_volts_bits    (req_volts_bits),
      .req_amps_bits     (req_amps_bits),
      .req_quality       (req_quality),
      .req_revision      (req_revision),
      .req_after_id      (req_after_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_has_sample    (rsp_has_sample),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_time_us   (rsp_out_time_us),
      .rsp_out_volts_bits(rsp_out_volts_bits),
      .rsp_out_amps_bits (rsp_out_amps_bits),
      .rsp_out_quality   (rsp_out_quality),
      .rsp_out_revision  (rsp_out_revision),
      .rsp_oldest_id     (rsp_oldest_id),
      .rsp_newest_id     (rsp_newest_id),
      .rsp_lost          (rsp_lost),
      .rsp_cursor        (rsp_cursor),
      .rsp_last          (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic shrq_pkg::rec_type random_record(logic [63:0] id);
      shrq_pkg::rec_type r;
      r.id         = id;
      r.time_us    = rand64();
      r.volts_bits = rand64();
      r.amps_bits  = rand64();
      r.quality    = $urandom;
      r.revision   = $urandom;
      return r;
   endfunction

   function automatic shrq_pkg::rec_type pattern_record(logic [63:0] id, logic [63:0] fill);
      shrq_pkg::rec_type r;
      r.id         = id;
      r.time_us    = fill;
      r.volts_bits = fill;
      r.amps_bits  = fill;
      r.quality    = fill[31:0];
      r.revision   = fill[63:32];
      return r;
   endfunction

   // position 0 is the oldest stored record
   function automatic int unsigned slot_at(int unsigned pos);
      return (hist_wr + DEPTH - hist_fill + pos) % DEPTH;
   endfunction

   function automatic logic [63:0] oldest_stored();
      return history[slot_at(0)].id;
   endfunction

   function automatic void store_record(shrq_pkg::rec_type r);
      history[hist_wr] = r;
      hist_wr = (hist_wr + 1) % DEPTH;
      if (hist_fill < DEPTH) hist_fill++;
   endfunction

   function automatic void answer_query(logic [63:0] after);
      shrq_pkg::rsp_type beat;
      logic [63:0]       oldest;
      logic [63:0]       newest;
      logic [63:0]       after_next;
      logic [63:0]       cur;
      logic              lost_flag;
      int unsigned       first;
      int unsigned       hi;
      int unsigned       mid;
      int unsigned       cnt;
      oldest = '0;
      newest = '0;
      if (hist_fill != 0) begin
         oldest = history[slot_at(0)].id;
         newest = history[slot_at(hist_fill - 1)].id;
      end
      after_next = after + 64'd1;
      lost_flag  = (after != 0) && (oldest != 0) && (after_next < oldest);
      first = 0;
      hi    = hist_fill;
      if (after != 0) begin
         while (first < hi) begin
            mid = first + (hi - first) / 2;
            if (history[slot_at(mid)].id <= after) first = mid + 1;
            else hi = mid;
         end
      end else begin
         first = (hist_fill > BATCH) ? hist_fill - BATCH : 0;
      end
      cnt = (hist_fill > first) ? hist_fill - first : 0;
      if (cnt > BATCH) cnt = BATCH;
      cur = (cnt != 0) ? history[slot_at(first + cnt - 1)].id : after;
      viewer_cursor = cur;
      beat = '0;
      beat.oldest_id = oldest;
      beat.newest_id = newest;
      beat.lost      = lost_flag;
      beat.cursor    = cur;
      if (cnt == 0) begin
         beat.last = 1'b1;
         pending_answers.push_back(beat);
         return;
      end
      for (int i = 0; i < cnt; i++) begin
         beat.has_sample = 1'b1;
         beat.rec        = history[slot_at(first + i)];
         beat.last       = (i + 1 == cnt);
         pending_answers.push_back(beat);
      end
   endfunction

   // hold the beat until taken, then update the prediction
   task automatic send_beat(input logic kind, input shrq_pkg::rec_type r,
                            input logic [63:0] after);
      int unsigned gap;
      gap = sender_idles ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_sample_id  <= r.id;
      req_time_us    <= r.time_us;
      req_volts_bits <= r.volts_bits;
      req_amps_bits  <= r.amps_bits;
      req_quality    <= r.quality;
      req_revision   <= r.revision;
      req_after_id   <= after;
      do @(posedge clock); while (req_stall);
      if (kind == shrq_pkg::KIND_PUSH) store_record(r);
      else answer_query(after);
   endtask

   task automatic push_record(shrq_pkg::rec_type r);
      send_beat(shrq_pkg::KIND_PUSH, r, rand64());
   endtask

   task automatic query_after(logic [63:0] after);
      send_beat(shrq_pkg::KIND_QUERY, random_record(rand64()), after);
   endtask

   task automatic push_next();
      logic [63:0] id;
      if ($urandom_range(0, 49) == 0) begin
         id = rand64();
      end else begin
         next_sample_id += ($urandom_range(0, 19) == 0) ? {32'd0, $urandom} :
                           64'($urandom_range(1, 3));
         id = next_sample_id;
      end
      push_record(random_record(id));
   endtask

   function automatic logic [63:0] pick_cursor();
      int unsigned pos;
      pos = $urandom_range(0, hist_fill - 1);
      case ($urandom_range(0, 9)) inside
         [0:2]:   return viewer_cursor;
         [3:4]:   return 64'd0;
         [5:6]:   return history[slot_at(pos)].id - 64'($urandom_range(0, 1));
         7:       return rand64();
         8:       return oldest_stored() - 64'($urandom_range(2, 6));
         default: return ($urandom_range(0, 1) != 0) ? '1 : history[slot_at(hist_fill - 1)].id;
      endcase
   endfunction

   task automatic test_empty_ring();
      query_after(64'd0);
      query_after('1);
      query_after(rand64());
   endtask

   task automatic test_lost_flag();
      push_record(pattern_record(64'd1000, '0));
      push_record(pattern_record(64'd1001, '1));
      push_record(pattern_record(64'd1002, {16{4'h5}}));
      push_record(pattern_record(64'd1003, {16{4'hA}}));
      query_after(64'd1);
      query_after(64'd998);
      query_after(64'd999);
      query_after(64'd1001);
   endtask

   task automatic test_extreme_fields();
      push_record(pattern_record({16{4'h5}}, {16{4'hA}}));
      push_record(pattern_record({16{4'hA}}, {16{4'h5}}));
      push_record(pattern_record('1, '1));
      query_after('1);
      query_after(64'd0);
      query_after({16{4'hA}});
   endtask

   task automatic test_unordered_ids();
      push_record(pattern_record(64'd0, '0));
      push_record(random_record(64'd42));
      query_after(64'd500);
      query_after(64'hFFFF_FFFF_FFFF_FFFE);
   endtask

   task automatic test_ring_wrap();
      logic [63:0] start;
      start          = rand64();
      next_sample_id = {2'b00, start[61:0]};
      sender_idles   = 1'b0;
      for (int n = 0; n < DEPTH + 100; n++) begin
         push_next();
         if (n % 700 == 699) query_after(viewer_cursor);
      end
      query_after(64'd0);
      query_after(oldest_stored() - 64'd3);
      query_after(oldest_stored() - 64'd1);
      query_after(history[slot_at(hist_fill - 1)].id - 64'd1);
      sender_idles = 1'b1;
   endtask

   task automatic test_back_pressure();
      hold_request = 400;
      query_after(64'd0);
      for (int n = 0; n < 20; n++) push_next();
      query_after(viewer_cursor);
   endtask

   task automatic test_random_traffic();
      for (int n = 0; n < 500; n++) begin
         if (n % 50 == 0) begin
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 4) == 0) query_after(pick_cursor());
         else push_next();
      end
   endtask

   // receiver: random stall runs, or a long hold when one is requested
   always @(posedge clock) begin
      if (hold_request != 0) begin
         rsp_stall    <= 1'b1;
         stall_left    = hold_request;
         hold_request  = 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end else begin
         rsp_stall  <= receiver_idles && ($urandom_range(0, 2) == 0);
         stall_left  = pick_gap();
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_beat
      shrq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("result beat with nothing expected: out_id %h cursor %h", rsp_out_id,
                   rsp_cursor);
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            check_field("has_sample", want.has_sample, rsp_has_sample);
            check_field("out_id", want.rec.id, rsp_out_id);
            check_field("out_time_us", want.rec.time_us, rsp_out_time_us);
            check_field("out_volts_bits", want.rec.volts_bits, rsp_out_volts_bits);
            check_field("out_amps_bits", want.rec.amps_bits, rsp_out_amps_bits);
            check_field("out_quality", want.rec.quality, rsp_out_quality);
            check_field("out_revision", want.rec.revision, rsp_out_revision);
            check_field("oldest_id", want.oldest_id, rsp_oldest_id);
            check_field("newest_id", want.newest_id, rsp_newest_id);
            check_field("lost", want.lost, rsp_lost);
            check_field("cursor", want.cursor, rsp_cursor);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_ring();
      test_lost_flag();
      test_extreme_fields();
      test_unordered_ids();
      test_ring_wrap();
      test_back_pressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (pending_answers.size() != 0) begin
         $error("%0d expected result beats never arrived", pending_answers.size());
         mismatches++;
      end
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/shrq_pkg.sv
rtl/shrq_ring.sv
rtl/shrq_seq.sv
rtl/sample_history_ring_with_cursor_query_top.sv
rtl/shrq_checker.sv
tb/tb_sample_history_ring_with_cursor_query_top.sv
